// ===== hw/rtl/teletext_line_buffer_adapter_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TELETEXT_LINE_BUFFER_ADAPTER_UNIT_MACROS_SVH
`define TELETEXT_LINE_BUFFER_ADAPTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ttlb_pkg.sv =====
package ttlb_pkg;

	localparam int RAM_AW = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REQ_RD    = 2'd0;
	localparam logic [1:0] REQ_WR    = 2'd1;
	localparam logic [1:0] REQ_CTRL  = 2'd2;
	localparam logic [1:0] REQ_FIELD = 2'd3;

	localparam logic [7:0] FRAMING_CODE = 8'h27;
	localparam logic [3:0] SYNC_ADVANCE = 4'd11;
	localparam logic [3:0] LAST_PACKET  = 4'hF;
	localparam logic [3:0] LAST_LINE    = 4'hF;

	// One RAM operation handed from the front end to the back end.
	typedef struct packed {
		logic              emit;     // produces a result
		logic              we;
		logic              rd;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        wdata;
		logic              nmi;
		logic              paged;
		logic [1:0]        chan;
	} op_t;

endpackage

// ===== hw/rtl/ttlb_front.sv =====
module ttlb_front import ttlb_pkg::*; #(
	parameter int LINE_BYTES = 42
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [9:0]  address,
	input  logic [7:0]  data_byte,
	input  logic        busy,
	input  logic        full,
	output logic        push,
	output op_t         push_op
);

	localparam int OFF_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(LINE_BYTES - 1);

	logic [3:0]       ctr_q, ctr_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic [3:0]       pkt_q, pkt_n;
	logic             open_q, open_n;
	logic             paged_q, paged_n;
	logic [1:0]       chan_q, chan_n;
	logic             pend_q;
	op_t              pend_op_q;

	logic             fire;
	logic             frame;
	logic [3:0]       ctr_f;
	logic             open_f;
	op_t              op;
	op_t              frame_op;

	assign in_ready = !busy && !pend_q && !full;
	assign fire = in_valid && in_ready;

	always_comb begin
		ctr_n = ctr_q;
		off_n = off_q;
		pkt_n = pkt_q;
		open_n = open_q;
		paged_n = paged_q;
		chan_n = chan_q;
		frame = 1'b0;
		ctr_f = ctr_q;
		open_f = open_q;
		op.emit = 1'b1;
		op.we = 1'b0;
		op.rd = 1'b0;
		op.addr = address;
		op.wdata = data_byte;
		op.nmi = 1'b0;
		op.paged = paged_q;
		op.chan = chan_q;
		case (req_type)
			REQ_RD: begin
				ctr_n = address[9:6];
				op.rd = 1'b1;
			end
			REQ_WR: begin
				ctr_n = address[9:6];
				op.we = 1'b1;
			end
			REQ_CTRL: begin
				chan_n = data_byte[1:0];
				paged_n = !data_byte[3];
				op.paged = paged_n;
				op.chan = chan_n;
			end
			REQ_FIELD: begin
				// field start: first byte of the first packet
				if (off_q == '0 && pkt_q == '0) begin
					ctr_f = ctr_q + SYNC_ADVANCE;
					open_f = 1'b1;
				end
				ctr_n = ctr_f;
				open_n = open_f;
				if (open_f) begin
					op.we = 1'b1;
					op.addr = {ctr_f, 6'b0} + RAM_AW'(off_q) + RAM_AW'(1);
					frame = (off_q == '0) && (data_byte != 8'h00);
					if (off_q == LAST_OFF) begin
						ctr_n = ctr_f + 4'd1;
						if (ctr_f == LAST_LINE)
							open_n = 1'b0;
					end
				end
				if (off_q == LAST_OFF) begin
					off_n = '0;
					pkt_n = pkt_q + 4'd1;
					op.nmi = (pkt_q == LAST_PACKET) && paged_q;
				end else begin
					off_n = off_q + OFF_W'(1);
				end
			end
			default: ;
		endcase
		frame_op.emit = 1'b0;
		frame_op.we = 1'b1;
		frame_op.rd = 1'b0;
		frame_op.addr = {ctr_f, 6'b0};
		frame_op.wdata = FRAMING_CODE;
		frame_op.nmi = 1'b0;
		frame_op.paged = paged_q;
		frame_op.chan = chan_q;
	end

	// The framing write goes first; the data write is held in pend_op_q and pushed once the queue has room.
	assign push = fire || (pend_q && !full);
	assign push_op = pend_q ? pend_op_q : (frame ? frame_op : op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			off_q <= '0;
			pkt_q <= '0;
			open_q <= 1'b1;
			paged_q <= 1'b1;
			chan_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (fire) begin
				ctr_q <= ctr_n;
				off_q <= off_n;
				pkt_q <= pkt_n;
				open_q <= open_n;
				paged_q <= paged_n;
				chan_q <= chan_n;
				pend_q <= frame;
			end else if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && frame)
			pend_op_q <= op;
	end

endmodule

// ===== hw/rtl/ttlb_queue.sv =====
module ttlb_queue import ttlb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output op_t  q_op
);

	op_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_op = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QUEUE_AW'(1);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_op;
	end

endmodule

// ===== hw/rtl/ttlb_back.sv =====
module ttlb_back import ttlb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       pop,
	output logic       busy,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       nmi_pulse,
	output logic       paged_in,
	output logic [1:0] channel_preset
);

	logic [7:0]        ram [2**RAM_AW];
	logic              busy_q;
	logic [RAM_AW-1:0] clr_q;

	logic              valid_s1;
	logic [7:0]        rdata_s1;
	logic              rd_s1;
	logic              nmi_s1;
	logic              paged_s1;
	logic [1:0]        chan_s1;

	logic              wen;
	logic [RAM_AW-1:0] waddr;
	logic [7:0]        wdat;
	logic              take;

	assign busy = busy_q;
	// non-result ops (framing writes) never wait on the output
	assign pop = q_valid && !busy_q && (!q_op.emit || !valid_s1 || out_ready);
	assign take = pop && q_op.emit;

	assign wen = busy_q || (pop && q_op.we);
	assign waddr = busy_q ? clr_q : q_op.addr;
	assign wdat = busy_q ? 8'h00 : q_op.wdata;

	always_ff @(posedge clk) begin
		if (wen)
			ram[waddr] <= wdat;
		if (take) begin
			rdata_s1 <= ram[q_op.addr];
			rd_s1 <= q_op.rd;
			nmi_s1 <= q_op.nmi;
			paged_s1 <= q_op.paged;
			chan_s1 <= q_op.chan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + RAM_AW'(1);
				if (clr_q == '1)
					busy_q <= 1'b0;
			end
			if (take)
				valid_s1 <= 1'b1;
			else if (out_ready)
				valid_s1 <= 1'b0;
		end
	end

	assign out_valid = valid_s1;
	assign read_data = rd_s1 ? rdata_s1 : 8'h00;
	assign nmi_pulse = nmi_s1;
	assign paged_in = paged_s1;
	assign channel_preset = chan_s1;

endmodule

// ===== hw/rtl/teletext_line_buffer_adapter_unit.sv =====
// Teletext adapter line buffer with a 1 KiB RAM. Takes one request per clock
// while in_ready is high: RAM read, RAM write, control write or received field
// byte, and returns one result per request in order. Each result passes through
// the four-entry queue and a registered output stage; a byte that also writes a
// framing code pushes the framing write first and its data write after it.
// Operations already waiting in the queue go first, and output stalls hold the
// result. A field byte that opens a packet with a nonzero value holds in_ready
// low until its data write is pushed, because the framing code and the data
// byte go into the queue as two writes. After reset the RAM is cleared one byte
// per cycle, and in_ready stays low until the clear is done.
module teletext_line_buffer_adapter_unit import ttlb_pkg::*; #(
	parameter int LINE_BYTES = 42
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [9:0] address,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       nmi_pulse,
	output logic       paged_in,
	output logic [1:0] channel_preset
);

	logic busy;
	logic full;
	logic push;
	op_t  push_op;
	logic pop;
	logic q_valid;
	op_t  q_op;

	ttlb_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.address  (address),
		.data_byte(data_byte),
		.busy     (busy),
		.full     (full),
		.push     (push),
		.push_op  (push_op)
	);

	ttlb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (full),
		.pop    (pop),
		.q_valid(q_valid),
		.q_op   (q_op)
	);

	ttlb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_op          (q_op),
		.pop           (pop),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.nmi_pulse     (nmi_pulse),
		.paged_in      (paged_in),
		.channel_preset(channel_preset)
	);

endmodule

// ===== hw/rtl/ttlb_checker.sv =====
`include "teletext_line_buffer_adapter_unit_macros.svh"

module ttlb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       nmi_pulse,
	input logic       paged_in,
	input logic [1:0] channel_preset
);

	logic       in_fire;
	logic       out_fire;
	logic [2:0] open_q;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			open_q <= '0;
		else if (in_fire && !out_fire)
			open_q <= open_q + 3'd1;
		else if (out_fire && !in_fire)
			open_q <= open_q - 3'd1;
	end

	`TTLB_ASSERT_NOW(a_nmi_paged, clk, arst_n, out_valid && nmi_pulse, paged_in, "nmi while paged out")
	`TTLB_ASSERT_NOW(a_no_orphan, clk, arst_n, out_valid, open_q != 3'd0, "result without request")
	`TTLB_ASSERT_NOW(a_in_flight, clk, arst_n, 1'b1, open_q <= 3'd6, "too many requests in flight")
	`TTLB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(nmi_pulse) && $stable(paged_in) && $stable(channel_preset), "stalled result changed")

endmodule

bind teletext_line_buffer_adapter_unit ttlb_checker u_ttlb_checker (.*);

// ===== verif/teletext_line_buffer_adapter_unit_tb.sv =====
`timescale 1ns / 1ps

module teletext_line_buffer_adapter_unit_tb;
	import ttlb_pkg::*;

	localparam int LINE_BYTES  = 42;
	localparam int FIELD_BYTES = 16 * LINE_BYTES;
	localparam int NUM_DIRECTED = 20;
	localparam int PHASE_ITEMS = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	// covers the RAM clear after reset plus the long receiver hold
	localparam int WATCHDOG = 4000;

	typedef struct packed {
		logic [7:0] rd;
		logic       nmi;
		logic       paged;
		logic [1:0] chan;
	} result_t;

	typedef struct packed {
		logic [1:0] req;
		logic [9:0] addr;
		logic [7:0] data;
		logic       typed;
		result_t    res;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [9:0] address;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic       nmi_pulse;
	logic       paged_in;
	logic [1:0] channel_preset;

	// typed-in expectation travelling with the offered request
	logic       cur_typed;
	result_t    cur_typed_res;

	int in_idle_pct;
	int out_stall_pct;
	logic hold_req;
	logic hold_done;

	int mismatch_cnt;
	int stuck_cycles;
	result_t awaited_results[$];

	// shadow state of the line buffer
	logic [7:0] shadow_ram [1024];
	logic [3:0] shadow_line;
	logic [9:0] shadow_pos;
	logic       shadow_open;
	logic       shadow_paged;
	logic [1:0] shadow_chan;

	dir_row_t dir_tab [NUM_DIRECTED] = '{
		'{REQ_RD,    10'd0,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_RD,    10'd1023, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_WR,    10'd1023, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_RD,    10'd1023, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b1, 2'd0}},
		'{REQ_WR,    10'd0,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_WR,    10'd512,  8'hA5, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_RD,    10'd512,  8'h00, 1'b1, '{8'hA5, 1'b0, 1'b1, 2'd0}},
		'{REQ_CTRL,  10'd0,    8'hFB, 1'b1, '{8'h00, 1'b0, 1'b0, 2'd3}},
		'{REQ_CTRL,  10'd1023, 8'hF7, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd3}},
		'{REQ_CTRL,  10'd341,  8'h04, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
		'{REQ_CTRL,  10'd682,  8'h09, 1'b1, '{8'h00, 1'b0, 1'b0, 2'd1}},
		'{REQ_CTRL,  10'd0,    8'h02, 1'b1, '{8'h00, 1'b0, 1'b1, 2'd2}},
		// field opens: framing code goes to the line base
		'{REQ_FIELD, 10'd0,    8'hFF, 1'b0, '0},
		'{REQ_FIELD, 10'd1023, 8'h00, 1'b0, '0},
		'{REQ_RD,    10'd192,  8'h00, 1'b0, '0},
		'{REQ_RD,    10'd193,  8'h00, 1'b0, '0},
		'{REQ_FIELD, 10'd1023, 8'h5A, 1'b0, '0},
		// host write mid-field reloads the line counter
		'{REQ_WR,    10'd960,  8'h3C, 1'b0, '0},
		'{REQ_FIELD, 10'd0,    8'hC3, 1'b0, '0},
		'{REQ_RD,    10'd964,  8'h00, 1'b0, '0}
	};

	teletext_line_buffer_adapter_unit #(
		.LINE_BYTES(LINE_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.address(address),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.nmi_pulse(nmi_pulse),
		.paged_in(paged_in),
		.channel_preset(channel_preset)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t next_adapter_result(logic [1:0] req, logic [9:0] addr,
			logic [7:0] d);
		result_t r;
		int off;
		logic [9:0] base;
		r = '0;
		case (req)
			REQ_RD: begin
				shadow_line = addr[9:6];
				r.rd = shadow_ram[addr];
			end
			REQ_WR: begin
				shadow_line = addr[9:6];
				shadow_ram[addr] = d;
			end
			REQ_CTRL: begin
				shadow_chan = d[1:0];
				shadow_paged = ~d[3];
			end
			default: begin
				if (int'(shadow_pos) >= FIELD_BYTES)
					shadow_pos = '0;
				if (shadow_pos == '0) begin
					shadow_line = shadow_line + SYNC_ADVANCE;
					shadow_open = 1'b1;
				end
				if (shadow_open) begin
					off = int'(shadow_pos) % LINE_BYTES;
					base = {shadow_line, 6'd0};
					if (off == 0 && d != 8'h00)
						shadow_ram[base] = FRAMING_CODE;
					shadow_ram[base + 10'd1 + 10'(off)] = d;
					if (off == LINE_BYTES - 1) begin
						if (shadow_line == LAST_LINE) begin
							shadow_line = '0;
							shadow_open = 1'b0;
						end else begin
							shadow_line = shadow_line + 4'd1;
						end
					end
				end
				if (int'(shadow_pos) == FIELD_BYTES - 1) begin
					shadow_pos = '0;
					r.nmi = shadow_paged;
				end else begin
					shadow_pos = shadow_pos + 10'd1;
				end
			end
		endcase
		r.paged = shadow_paged;
		r.chan = shadow_chan;
		return r;
	endfunction

	// Request side monitor first, then result side, so a same-edge push is seen.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = next_adapter_result(req_type, address, data_byte);
				if (cur_typed)
					want = cur_typed_res;
				awaited_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: read_data %h nmi_pulse %b", read_data, nmi_pulse);
					mismatch_cnt++;
				end else begin
					want = awaited_results.pop_front();
					if (read_data !== want.rd) begin
						$error("read_data: expected %h, got %h", want.rd, read_data);
						mismatch_cnt++;
					end
					if (nmi_pulse !== want.nmi) begin
						$error("nmi_pulse: expected %b, got %b", want.nmi, nmi_pulse);
						mismatch_cnt++;
					end
					if (paged_in !== want.paged) begin
						$error("paged_in: expected %b, got %b", want.paged, paged_in);
						mismatch_cnt++;
					end
					if (channel_preset !== want.chan) begin
						$error("channel_preset: expected %h, got %h", want.chan,
							channel_preset);
						mismatch_cnt++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		out_ready <= 1'b0;
		hold_done <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done <= 1'b1;
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	task automatic offer_request(logic [1:0] req, logic [9:0] addr, logic [7:0] d,
			logic typed, result_t res);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		address <= addr;
		data_byte <= d;
		cur_typed <= typed;
		cur_typed_res <= res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic offer_random;
		int pick;
		logic [7:0] d;
		pick = $urandom_range(99);
		d = 8'($urandom);
		if (pick < 12) begin
			offer_request(REQ_RD, 10'($urandom), 8'($urandom), 1'b0, '0);
		end else if (pick < 19) begin
			offer_request(REQ_WR, 10'($urandom), d, 1'b0, '0);
		end else if (pick < 23) begin
			// mostly stay paged in so end-of-field NMIs show up
			if ($urandom_range(3) != 0)
				d[3] = 1'b0;
			offer_request(REQ_CTRL, 10'($urandom), d, 1'b0, '0);
		end else begin
			if ($urandom_range(3) == 0)
				d = 8'h00;
			offer_request(REQ_FIELD, 10'($urandom), d, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_RD;
		address <= '0;
		data_byte <= '0;
		cur_typed <= 1'b0;
		cur_typed_res <= '0;
		hold_req <= 1'b0;
		out_stall_pct <= 0;
		in_idle_pct = 0;
		mismatch_cnt = 0;
		stuck_cycles = 0;
		for (int i = 0; i < 1024; i++)
			shadow_ram[i] = 8'h00;
		shadow_line = '0;
		shadow_pos = '0;
		shadow_open = 1'b1;
		shadow_paged = 1'b1;
		shadow_chan = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_request(dir_tab[i].req, dir_tab[i].addr, dir_tab[i].data,
				dir_tab[i].typed, dir_tab[i].res);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
				1: begin in_idle_pct = 46; out_stall_pct <= 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct <= 46; end
				default: begin in_idle_pct = 38; out_stall_pct <= 38; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold while requests keep coming
				if (ph == 0 && n == 200)
					hold_req <= 1'b1;
				offer_random();
			end
		end
		in_valid <= 1'b0;
		cur_typed <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
